// ----- rtl/irch_pkg.sv -----
// irch_pkg: shared types and constants for the interval room counter.
// No dependencies; imported by irch_mem and interval_room_count_heap.
package irch_pkg;

   localparam int TIME_W        = 32;    // start/end time width
   localparam int ROOMS_W       = 11;    // width of the reported room count
   localparam int HEAP_DEPTH_DEF = 1024; // default heap capacity

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,      // waiting for a request word
      ST_ROOT_RD,   // read heap root
      ST_ROOT_CMP,  // decide reuse / insert / overflow
      ST_UP,        // sift-up: read parent or place value at top
      ST_UP_CMP,    // sift-up: compare parent, move it down or place value
      ST_DN_L,      // sift-down: read left child or place value at a leaf
      ST_DN_R,      // sift-down: take left child, read right child
      ST_DN_CMP,    // sift-down: pick smallest, move it up or place value
      ST_DONE       // hand result to the output register
   } state_type;

   // end/start times kept with the sign bit flipped: unsigned compare orders them
   function automatic logic [TIME_W-1:0] to_key(input logic [TIME_W-1:0] v);
      to_key = v ^ {1'b1, {(TIME_W-1){1'b0}}};
   endfunction

endpackage

// ----- rtl/irch_mem.sv -----
// irch_mem: single-clock heap storage, one write and one read port.
// Read data is registered. Depends on irch_pkg.
module irch_mem
   import irch_pkg::*;
#(
   parameter int DEPTH = HEAP_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [TIME_W-1:0] wdata,
   input  logic [AW-1:0]     raddr,
   output logic [TIME_W-1:0] rdata
);

   logic [TIME_W-1:0] mem [DEPTH];
   logic [TIME_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/interval_room_count_heap.sv -----
// interval_room_count_heap: min-heap of end times in one synchronous RAM.
// A word reads the heap root, then either inserts its end (sift-up), reuses the root
// (sift-down) or overflows with no sift move. The slowest word is a reuse that sinks
// 10 levels in a full heap. The next word is taken only once the last result is queued
// in the output register, so a stalled response holds the request side back.
// Reset: state machine, room count and output valid clear; heap RAM is not cleared.
module interval_room_count_heap
   import irch_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [TIME_W-1:0] req_start_time,
   input  logic signed [TIME_W-1:0] req_end_time,
   input  logic                     req_last,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ROOMS_W-1:0]       rsp_rooms,
   output logic                     rsp_final_res,
   output logic                     rsp_overflow
);

   localparam int AW    = $clog2(HEAP_DEPTH);        // heap index width
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);    // count holds 0..HEAP_DEPTH
   localparam int CW    = AW + 2;                    // child index, no wrap
   localparam int XW    = (CNT_W > ROOMS_W) ? CNT_W : ROOMS_W;

   state_type state_ff, state_in;

   // current word (keys already sign-flipped)
   logic [TIME_W-1:0] s_ff, s_in;
   logic [TIME_W-1:0] e_ff, e_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;

   logic [CNT_W-1:0]  count_ff, count_in;

   // sift walker: hole position, value being placed, best child so far
   logic [AW-1:0]     pos_ff, pos_in;
   logic [TIME_W-1:0] val_ff, val_in;
   logic [AW-1:0]     m_ff, m_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic              r_ok_ff, r_ok_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROOMS_W-1:0] rooms_ff, rooms_in;
   logic               final_ff, final_in;
   logic               rovf_ff, rovf_in;

   // memory port
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [TIME_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [TIME_W-1:0] mem_rdata;

   // shared decode
   logic              req_acc;
   logic              out_free;
   logic              reuse;
   logic              room_left;
   logic [AW-1:0]     parent;
   logic [CW-1:0]     lidx, ridx, size_x;
   logic              l_ok, r_ok;
   logic              take_r;
   logic [AW-1:0]     pick_idx;
   logic [TIME_W-1:0] pick_val;
   logic              moved;
   logic [XW-1:0]     count_x;

   irch_mem #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // root holds the smallest end; a room frees up if it ends by the new start
   assign reuse     = (count_ff != '0) && (mem_rdata <= s_ff);
   assign room_left = count_ff < CNT_W'(HEAP_DEPTH);

   assign parent = (pos_ff - AW'(1)) >> 1;
   assign lidx   = (CW'(pos_ff) << 1) + CW'(1);
   assign ridx   = (CW'(pos_ff) << 1) + CW'(2);
   assign size_x = CW'(count_ff);
   assign l_ok   = lidx < size_x;
   assign r_ok   = ridx < size_x;

   // right child only wins on strict less, so the left one takes ties
   assign take_r   = r_ok_ff && (mem_rdata < best_ff);
   assign pick_idx = take_r ? ridx[AW-1:0] : m_ff;
   assign pick_val = take_r ? mem_rdata : best_ff;
   assign moved    = take_r || (m_ff != pos_ff);

   assign count_x = XW'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_ROOT_RD;
         end
         ST_ROOT_RD: state_in = ST_ROOT_CMP;
         ST_ROOT_CMP: begin
            if (reuse)          state_in = ST_DN_L;
            else if (room_left) state_in = ST_UP;
            else                state_in = ST_DONE;
         end
         ST_UP: begin
            if (pos_ff == '0) state_in = ST_DONE;
            else              state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            if (mem_rdata <= val_ff) state_in = ST_DONE;
            else                     state_in = ST_UP;
         end
         ST_DN_L: begin
            if (l_ok) state_in = ST_DN_R;
            else      state_in = ST_DONE;
         end
         ST_DN_R: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (moved) state_in = ST_DN_L;
            else       state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      s_in      = s_ff;
      e_in      = e_ff;
      last_in   = last_ff;
      ovf_in    = ovf_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      m_in      = m_ff;
      best_in   = best_ff;
      r_ok_in   = r_ok_ff;
      rooms_in  = rooms_ff;
      final_in  = final_ff;
      rovf_in   = rovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = val_ff;
      mem_raddr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               s_in    = to_key(req_start_time);
               e_in    = to_key(req_end_time);
               last_in = req_last;
               ovf_in  = 1'b0;
            end
         end
         ST_ROOT_RD: begin
            mem_raddr = '0;
         end
         ST_ROOT_CMP: begin
            if (reuse) begin
               // new end replaces the root, then sinks
               pos_in = '0;
               val_in = e_ff;
            end else if (room_left) begin
               // new end appended at the tail, then rises
               pos_in   = AW'(count_ff);
               val_in   = e_ff;
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         ST_UP: begin
            if (pos_ff == '0) begin
               mem_we = 1'b1;
            end else begin
               mem_raddr = parent;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (mem_rdata > val_ff) begin
               // parent larger: it drops into the hole
               mem_wdata = mem_rdata;
               pos_in    = parent;
            end
         end
         ST_DN_L: begin
            if (l_ok) begin
               mem_raddr = lidx[AW-1:0];
            end else begin
               mem_we = 1'b1;
            end
         end
         ST_DN_R: begin
            if (mem_rdata < val_ff) begin
               m_in    = lidx[AW-1:0];
               best_in = mem_rdata;
            end else begin
               m_in    = pos_ff;
               best_in = val_ff;
            end
            r_ok_in = r_ok;
            if (r_ok) mem_raddr = ridx[AW-1:0];
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (moved) begin
               // smaller child rises into the hole
               mem_wdata = pick_val;
               pos_in    = pick_idx;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rooms_in     = count_x[ROOMS_W-1:0];
               final_in     = last_ff;
               rovf_in      = ovf_ff;
               if (last_ff) count_in = '0;   // set finished, start over
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      e_ff     <= e_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      m_ff     <= m_in;
      best_ff  <= best_in;
      r_ok_ff  <= r_ok_in;
      rooms_ff <= rooms_in;
      final_ff <= final_in;
      rovf_ff  <= rovf_in;
   end

   // a new word is taken only while idle; a queued result does not block it
   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rooms     = rooms_ff;
   assign rsp_final_res = final_ff;
   assign rsp_overflow  = rovf_ff;

endmodule

// ----- test/interval_room_count_heap_test.sv -----
// Self-checking testbench for interval_room_count_heap: a directed table, then random sets.
// A heap predictor checks all but typed table rows. Needs irch_pkg and the RTL of the block.
`timescale 1ns / 100ps

module interval_room_count_heap_test;
   import irch_pkg::*;

   localparam int          HEAP_SLOTS   = HEAP_DEPTH_DEF;
   localparam int          ITEMS_TARGET = 1400;
   localparam int          FILL_AFTER   = 200;     // overflow set starts once this many words are sent
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam logic [TIME_W-1:0] KEY_FLIP = 32'h8000_0000;
   localparam logic [TIME_W-1:0] T_MIN    = 32'h8000_0000;
   localparam logic [TIME_W-1:0] T_MAX    = 32'h7FFF_FFFF;

   // one response word as the block reports it
   typedef struct packed {
      logic [ROOMS_W-1:0] rooms;
      logic               final_res;
      logic               overflow;
   } room_word_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct {
      logic [TIME_W-1:0] st;
      logic [TIME_W-1:0] en;
      bit                lst;
      bit                typed;
      room_word_type     want;
   } probe_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [TIME_W-1:0] req_start_time;
   logic signed [TIME_W-1:0] req_end_time;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [ROOMS_W-1:0]       rsp_rooms;
   logic                     rsp_final_res;
   logic                     rsp_overflow;

   // predictor state: end times kept as sign-flipped keys, so plain unsigned
   // compares order them like signed times
   logic [TIME_W-1:0] room_ends [HEAP_SLOTS];
   int                open_rooms;

   room_word_type expected_counts [$];
   int            mismatches;
   int            words_sent;
   int unsigned   cycle_count;

   // response-side stall pattern
   int stall_left;
   bit stall_hold;

   interval_room_count_heap uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rooms      (rsp_rooms),
      .rsp_final_res  (rsp_final_res),
      .rsp_overflow   (rsp_overflow)
   );

   // Directed table. Covers: first word after reset, the signed extremes on both
   // fields, reuse on an equal end/start, tied ends on insert and on sift-down
   // (two equal children, the left one must win), starts out of order, single-word
   // sets, the clear after a last word, and the sign bit set and clear everywhere.
   probe_type probes [21] = '{
      '{T_MIN,        T_MAX,        1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{T_MAX,        T_MIN,        1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{T_MIN,        32'h0000_0000, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_000A, 32'h0000_0014, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0003, 32'h0000_0064, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0007, 32'h0000_0007, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}},
      '{32'h0000_0000, T_MAX,        1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{T_MIN,        32'h0000_0005, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{T_MIN,        32'h0000_0009, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{T_MIN,        32'h0000_0009, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0006, 32'h0000_0014, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0009, 32'h0000_001E, 1'b0, 1'b0, '{11'd0, 1'b0, 1'b0}},
      '{32'h0000_0064, 32'h0000_0065, 1'b1, 1'b0, '{11'd0, 1'b0, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Heap predictor. Reuse the earliest-free room when its end is at most the new
   // start (root replaced, sifted down); otherwise open a room (appended, sifted up);
   // a full heap drops the open and flags overflow. Last clears the count after the
   // word is formed.
   function automatic room_word_type predict_rooms(input logic [TIME_W-1:0] st,
                                                   input logic [TIME_W-1:0] en,
                                                   input bit lst);
      logic [TIME_W-1:0] s_key;
      logic [TIME_W-1:0] e_key;
      logic [TIME_W-1:0] swap;
      int                pos;
      int                lc;
      int                pick;
      room_word_type     w;
      s_key = st ^ KEY_FLIP;
      e_key = en ^ KEY_FLIP;
      w.overflow = 1'b0;
      if (open_rooms != 0 && room_ends[0] <= s_key) begin
         room_ends[0] = e_key;
         pos = 0;
         forever begin
            lc   = 2 * pos + 1;
            pick = pos;
            if (lc < open_rooms && room_ends[lc] < room_ends[pick])
               pick = lc;
            // strict compare: on equal children the left one stays picked
            if (lc + 1 < open_rooms && room_ends[lc + 1] < room_ends[pick])
               pick = lc + 1;
            if (pick == pos)
               break;
            swap            = room_ends[pick];
            room_ends[pick] = room_ends[pos];
            room_ends[pos]  = swap;
            pos             = pick;
         end
      end else if (open_rooms < HEAP_SLOTS) begin
         room_ends[open_rooms] = e_key;
         pos = open_rooms;
         while (pos > 0) begin
            pick = (pos - 1) >> 1;
            if (room_ends[pick] <= room_ends[pos])
               break;
            swap            = room_ends[pick];
            room_ends[pick] = room_ends[pos];
            room_ends[pos]  = swap;
            pos             = pick;
         end
         open_rooms++;
      end else begin
         w.overflow = 1'b1;
      end
      w.rooms     = ROOMS_W'(open_rooms);
      w.final_res = lst;
      if (lst)
         open_rooms = 0;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Called just after a falling edge; returns just after the falling edge that
   // follows acceptance, with req_valid still high.
   task automatic send_word(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] en,
                            input bit lst, input bit typed, input room_word_type want);
      room_word_type predicted;
      req_start_time <= st;
      req_end_time   <= en;
      req_last       <= lst;
      req_valid      <= 1'b1;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      predicted = predict_rooms(st, en, lst);
      expected_counts.push_back(typed ? want : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55)
         return 0;
      else if (p < 85)
         return $urandom_range(1, 3);
      else if (p < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic idle_sender(input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Hold off the request side until the block has answered everything.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_counts.size() != 0);
   endtask

   // One set of intervals. Ordered sets step the start forward a little and give
   // short durations so rooms get reused; noise sets take raw random words.
   task automatic send_random_set(input int len, input bit ordered, input bit tight);
      logic [TIME_W-1:0] st;
      logic [TIME_W-1:0] en;
      int                kind;
      int                step_max;
      int                span;
      room_word_type     none;
      none     = '0;
      kind     = $urandom_range(0, 99);
      step_max = $urandom_range(0, 30);
      span     = (kind < 50) ? $urandom_range(1, 60) : $urandom_range(60, 5000);
      if (kind < 70)
         st = $urandom;
      else if (kind < 85)
         st = T_MIN + $urandom_range(0, 100);
      else
         st = T_MAX - $urandom_range(0, 5000);
      for (int i = 0; i < len; i++) begin
         if (ordered) begin
            st = st + $urandom_range(0, step_max);
            en = ($urandom_range(0, 9) == 0) ? $urandom : st + $urandom_range(0, span);
         end else begin
            st = $urandom;
            en = $urandom;
         end
         send_word(st, en, i == len - 1, 1'b0, none);
         idle_sender(tight ? 0 : pick_gap());
      end
   endtask

   // Fills the heap to the top and two words past it: every start is the most negative
   // time and no end equals it, so no room is ever free. Then rooms are reused
   // while full, with the last word closing the set at the full count.
   task automatic send_overflow_set();
      logic [TIME_W-1:0] en;
      room_word_type     none;
      none = '0;
      for (int i = 0; i < HEAP_SLOTS + 2; i++) begin
         en = $urandom;
         if (en == T_MIN)
            en = T_MAX;
         send_word(T_MIN, en, 1'b0, 1'b0, none);
         idle_sender(($urandom_range(0, 3) == 0) ? pick_gap() : 0);
      end
      for (int i = 0; i < 3; i++) begin
         send_word(T_MAX, $urandom, i == 2, 1'b0, none);
         idle_sender(pick_gap());
      end
   endtask

   // Response side: free-running stretches, short stalls, the odd long stall.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               stall_hold = 1'b0;
               stall_left = $urandom_range(10, 60);
            end
            3, 4, 5, 6, 7: begin
               stall_hold = 1'($urandom_range(0, 1));
               stall_left = $urandom_range(1, 3);
            end
            8: begin
               stall_hold = 1'b1;
               stall_left = $urandom_range(4, 12);
            end
            default: begin
               stall_hold = ($urandom_range(0, 3) == 0);
               stall_left = $urandom_range(20, 50);
            end
         endcase
      end
      rsp_stall <= stall_hold;
      stall_left--;
   end

   // Response checker: every accepted word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("unexpected response word, rooms", 32'(rsp_rooms), 0);
         end else begin
            if (rsp_rooms !== expected_counts[0].rooms)
               report_mismatch("rooms", 32'(rsp_rooms), 32'(expected_counts[0].rooms));
            if (rsp_final_res !== expected_counts[0].final_res)
               report_mismatch("final_res", 32'(rsp_final_res),
                               32'(expected_counts[0].final_res));
            if (rsp_overflow !== expected_counts[0].overflow)
               report_mismatch("overflow", 32'(rsp_overflow),
                               32'(expected_counts[0].overflow));
            void'(expected_counts.pop_front());
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d response words outstanding", $time,
                  expected_counts.size());
         $display("[interval_room_count_heap] ERROR");
         $finish;
      end
   end

   initial begin
      bit filled;
      int len;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_time = '0;
      req_end_time   = '0;
      req_last       = 1'b0;
      rsp_stall      = 1'b0;
      stall_left     = 0;
      stall_hold     = 1'b0;
      open_rooms     = 0;
      mismatches     = 0;
      words_sent     = 0;
      cycle_count    = 0;
      filled         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (probes[i]) begin
         send_word(probes[i].st, probes[i].en, probes[i].lst, probes[i].typed,
                   probes[i].want);
         idle_sender(pick_gap());
      end
      pause_until_drained();

      // random sets; every set ends with a last word so the next one starts empty
      while (words_sent < ITEMS_TARGET) begin
         if (!filled && words_sent >= FILL_AFTER) begin
            send_overflow_set();
            pause_until_drained();
            filled = 1'b1;
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         send_random_set(len, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0)
            pause_until_drained();
      end
      req_valid <= 1'b0;

      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("[interval_room_count_heap] OK");
      else
         $display("[interval_room_count_heap] ERROR");
      $finish;
   end

endmodule
